// File: sv/sda_pkg.sv
package sda_pkg;

  localparam int SDA_MAX_PLACES = 18;
  localparam int QUEUE_DEPTH    = 2;

  typedef enum logic [2:0] {
    MODE_ADD    = 3'd0,
    MODE_SUB    = 3'd1,
    MODE_MUL    = 3'd2,
    MODE_ROUND  = 3'd3,
    MODE_SHRINK = 3'd4,
    MODE_EQUAL  = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    OP_ZERO,
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_RND_UP,
    OP_RND_DN,
    OP_SHRINK,
    OP_EQUAL
  } op_t;

  // classified transaction handed from front to back
  typedef struct packed {
    op_t         op;
    logic [63:0] a;
    logic [63:0] b;
    logic [4:0]  expo;
    logic        scale_a;
    logic [4:0]  places;
    logic        ovf;
    logic        eq;
  } job_t;

  function automatic logic [63:0] pow_ten(input logic [4:0] e);
    logic [63:0] p;
    case (e)
      5'd0:    p = 64'd1;
      5'd1:    p = 64'd10;
      5'd2:    p = 64'd100;
      5'd3:    p = 64'd1000;
      5'd4:    p = 64'd10000;
      5'd5:    p = 64'd100000;
      5'd6:    p = 64'd1000000;
      5'd7:    p = 64'd10000000;
      5'd8:    p = 64'd100000000;
      5'd9:    p = 64'd1000000000;
      5'd10:   p = 64'd10000000000;
      5'd11:   p = 64'd100000000000;
      5'd12:   p = 64'd1000000000000;
      5'd13:   p = 64'd10000000000000;
      5'd14:   p = 64'd100000000000000;
      5'd15:   p = 64'd1000000000000000;
      5'd16:   p = 64'd10000000000000000;
      5'd17:   p = 64'd100000000000000000;
      default: p = 64'd1000000000000000000;
    endcase
    return p;
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

endpackage

// File: sv/sda_front.sv
module sda_front import sda_pkg::*; #(
  parameter int MAX_PLACES = SDA_MAX_PLACES
) (
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         mode,
  input  logic signed [63:0] a_value,
  input  logic [4:0]         a_places,
  input  logic signed [63:0] b_value,
  input  logic [4:0]         b_places,
  input  logic [4:0]         target_places,
  input  logic               full,
  output logic               push,
  output job_t               job
);

  localparam logic [4:0] MAX_P = 5'(MAX_PLACES);

  logic       oa, ob, ot;
  logic [4:0] pa, pb, pt;
  logic [5:0] psum;

  assign in_stall = full;
  assign push     = in_valid && !full;

  always_comb begin
    oa   = a_places > MAX_P;
    ob   = b_places > MAX_P;
    ot   = target_places > MAX_P;
    pa   = oa ? MAX_P : a_places;
    pb   = ob ? MAX_P : b_places;
    pt   = ot ? MAX_P : target_places;
    psum = {1'b0, pa} + {1'b0, pb};
    job.op      = OP_ZERO;
    job.a       = a_value;
    job.b       = b_value;
    job.expo    = 5'd0;
    job.scale_a = 1'b0;
    job.places  = 5'd0;
    job.ovf     = 1'b0;
    job.eq      = 1'b0;
    case (mode_t'(mode))
      MODE_ADD, MODE_SUB: begin
        job.op  = (mode_t'(mode) == MODE_ADD) ? OP_ADD : OP_SUB;
        job.ovf = oa | ob;
        if (pa < pb) begin
          job.scale_a = 1'b1;
          job.expo    = pb - pa;
          job.places  = pb;
        end else begin
          job.expo   = pa - pb;
          job.places = pa;
        end
      end
      MODE_MUL: begin
        job.op = OP_MUL;
        if (psum > {1'b0, MAX_P}) begin
          job.places = MAX_P;
          job.ovf    = 1'b1;
        end else begin
          job.places = psum[4:0];
          job.ovf    = oa | ob;
        end
      end
      MODE_ROUND: begin
        job.ovf    = oa | ot;
        job.places = pt;
        if (pa > pt) begin
          job.op   = OP_RND_DN;
          job.expo = pa - pt;
        end else begin
          job.op   = OP_RND_UP;
          job.expo = pt - pa;
        end
      end
      MODE_SHRINK: begin
        job.op     = OP_SHRINK;
        job.ovf    = oa;
        job.places = pa;
      end
      MODE_EQUAL: begin
        job.op = OP_EQUAL;
        job.eq = (a_value == b_value) && (a_places == b_places);
      end
      default: job.op = OP_ZERO;
    endcase
  end

endmodule

// File: sv/sda_queue.sv
module sda_queue import sda_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t job_in,
  output logic full,
  input  logic pop,
  output job_t job_out,
  output logic empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = count == CNT_W'(QUEUE_DEPTH);
  assign empty   = count == '0;
  assign job_out = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: sv/sda_back.sv
module sda_back import sda_pkg::*; #(
  parameter int MAX_PLACES = SDA_MAX_PLACES
) (
  input  logic               clk,
  input  logic               rst,
  input  job_t               job,
  input  logic               empty,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] result_value,
  output logic [4:0]         result_places,
  output logic               is_equal,
  output logic               overflow
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_DIV  = 5'b00100,
    S_FIN  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  localparam logic [63:0] SIGN = 64'h8000_0000_0000_0000;

  state_t      state;
  logic [5:0]  cnt;
  logic [4:0]  digs;
  op_t         op;
  logic        scale_a, mul_neg, a_neg;
  logic [63:0] other, ma, hi, lo, quo, mag, res;
  logic [3:0]  rem;
  logic [4:0]  places;
  logic        ovf, eq, load;

  logic [64:0] mul_sum;
  logic [63:0] prod, lim, x, y, sum_add, sum_sub, q1, rq, smag, job_mag;
  logic [7:0]  dq;
  logic [4:0]  dt;
  logic [3:0]  dr;
  logic        p_ovf, add_ovf, sub_ovf, inc, zrem, more;
  logic [4:0]  sp;

  assign pop     = (state == S_IDLE) && !empty;
  assign job_mag = mag64(job.a);

  always_comb begin
    mul_sum = {1'b0, hi} + (lo[0] ? {1'b0, ma} : 65'd0);
    // divide by ten, eight dividend bits per cycle
    dr = rem;
    dt = 5'd0;
    dq = 8'd0;
    for (int i = 0; i < 8; i++) begin
      dt        = {dr, quo[63 - i]};
      dq[7 - i] = dt >= 5'd10;
      dr        = dq[7 - i] ? 4'(dt - 5'd10) : dt[3:0];
    end
    prod    = mul_neg ? (64'd0 - lo) : lo;
    lim     = mul_neg ? SIGN : (SIGN - 64'd1);
    p_ovf   = (hi != 64'd0) || (lo > lim);
    x       = scale_a ? prod : other;
    y       = scale_a ? other : prod;
    sum_add = x + y;
    sum_sub = x - y;
    add_ovf = !(x[63] ^ y[63]) && (sum_add[63] ^ x[63]);
    sub_ovf = (x[63] ^ y[63]) && (sum_sub[63] ^ x[63]);
    // half away from zero: the last digit dropped decides
    inc     = rem >= 4'd5;
    q1      = quo + 64'(inc);
    rq      = a_neg ? (64'd0 - q1) : q1;
    zrem    = rem == 4'd0;
    smag    = zrem ? quo : mag;
    sp      = zrem ? places - 5'd1 : places;
    more    = zrem && (quo != 64'd0) && (sp != 5'd0);
    load    = (state == S_OUT) && (!out_valid || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (!empty) begin
            op      <= job.op;
            places  <= job.places;
            ovf     <= job.ovf;
            eq      <= job.eq;
            scale_a <= job.scale_a;
            a_neg   <= job.a[63];
            hi      <= 64'd0;
            rem     <= 4'd0;
            case (job.op)
              OP_ADD, OP_SUB: begin
                lo    <= pow_ten(job.expo);
                cnt   <= 6'd63;
                state <= S_MUL;
                if (job.scale_a) begin
                  ma      <= job_mag;
                  mul_neg <= job.a[63];
                  other   <= job.b;
                end else begin
                  ma      <= mag64(job.b);
                  mul_neg <= job.b[63];
                  other   <= job.a;
                end
              end
              OP_MUL: begin
                ma      <= job_mag;
                lo      <= mag64(job.b);
                mul_neg <= job.a[63] ^ job.b[63];
                cnt     <= 6'd63;
                state   <= S_MUL;
              end
              OP_RND_UP: begin
                ma      <= job_mag;
                lo      <= pow_ten(job.expo);
                mul_neg <= job.a[63];
                cnt     <= 6'd63;
                state   <= S_MUL;
              end
              OP_RND_DN: begin
                quo   <= job_mag;
                digs  <= job.expo;
                cnt   <= 6'd7;
                state <= S_DIV;
              end
              OP_SHRINK: begin
                mag   <= job_mag;
                quo   <= job_mag;
                res   <= job.a;
                cnt   <= 6'd7;
                state <= (job_mag != 64'd0 && job.places != 5'd0) ? S_DIV : S_OUT;
              end
              default: begin
                res   <= 64'd0;
                state <= S_OUT;
              end
            endcase
          end
        end
        S_MUL: begin
          hi  <= mul_sum[64:1];
          lo  <= {mul_sum[0], lo[63:1]};
          cnt <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            state <= S_FIN;
          end
        end
        S_DIV: begin
          quo <= {quo[55:0], dq};
          rem <= dr;
          cnt <= cnt - 6'd1;
          if (cnt == 6'd0) begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          case (op)
            OP_ADD: begin
              res   <= sum_add;
              ovf   <= ovf | p_ovf | add_ovf;
              state <= S_OUT;
            end
            OP_SUB: begin
              res   <= sum_sub;
              ovf   <= ovf | p_ovf | sub_ovf;
              state <= S_OUT;
            end
            OP_MUL, OP_RND_UP: begin
              res   <= prod;
              ovf   <= ovf | p_ovf;
              state <= S_OUT;
            end
            OP_RND_DN: begin
              if (digs != 5'd1) begin
                digs  <= digs - 5'd1;
                rem   <= 4'd0;
                cnt   <= 6'd7;
                state <= S_DIV;
              end else begin
                res   <= rq;
                state <= S_OUT;
              end
            end
            OP_SHRINK: begin
              mag    <= smag;
              places <= sp;
              res    <= a_neg ? (64'd0 - smag) : smag;
              if (more) begin
                quo   <= smag;
                rem   <= 4'd0;
                cnt   <= 6'd7;
                state <= S_DIV;
              end else begin
                state <= S_OUT;
              end
            end
            default: begin
              res   <= 64'd0;
              state <= S_OUT;
            end
          endcase
        end
        S_OUT: begin
          if (load) begin
            result_value  <= res;
            result_places <= places;
            is_equal      <= eq;
            overflow      <= ovf;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_pop_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> state != S_IDLE)
    else $error("back stayed idle after taking a transaction");

  a_places_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> result_places <= 5'(MAX_PLACES))
    else $error("result places above limit");

  a_equal_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_equal) |-> (result_value == 64'sd0 && !overflow))
    else $error("equal result carries value or overflow");

  a_mul_runs: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL && cnt != 6'd0) |=> state == S_MUL)
    else $error("multiplier left early");

endmodule

// File: sv/scaled_decimal_alu.sv
// add, subtract, multiply and round to more places run the bit-serial multiplier; equal goes straight to output
// round to fewer places divides by ten once per place dropped; shrink divides once per digit tested
// the multiplier is bit-serial, and each divide by ten is followed by one check step
// the back finishes one transaction before it takes the next, and waits while the output is held off
// a two-entry queue lets the front accept while the back is busy
// reset clears the queue and the back state machine; no result pending after
module scaled_decimal_alu import sda_pkg::*; #(
  parameter int MAX_PLACES = SDA_MAX_PLACES
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         mode,
  input  logic signed [63:0] a_value,
  input  logic [4:0]         a_places,
  input  logic signed [63:0] b_value,
  input  logic [4:0]         b_places,
  input  logic [4:0]         target_places,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] result_value,
  output logic [4:0]         result_places,
  output logic               is_equal,
  output logic               overflow
);

  job_t front_job, back_job;
  logic push, full, pop, empty;

  sda_front #(.MAX_PLACES(MAX_PLACES)) u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .mode          (mode),
    .a_value       (a_value),
    .a_places      (a_places),
    .b_value       (b_value),
    .b_places      (b_places),
    .target_places (target_places),
    .full          (full),
    .push          (push),
    .job           (front_job)
  );

  sda_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .job_in  (front_job),
    .full    (full),
    .pop     (pop),
    .job_out (back_job),
    .empty   (empty)
  );

  sda_back #(.MAX_PLACES(MAX_PLACES)) u_back (
    .clk           (clk),
    .rst           (rst),
    .job           (back_job),
    .empty         (empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_value  (result_value),
    .result_places (result_places),
    .is_equal      (is_equal),
    .overflow      (overflow)
  );

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import sda_pkg::*;

  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;
  localparam int         PLACE_LIMIT = 18;
  localparam int         SETTLE_CYCLES = 1300;

  typedef struct {
    logic [63:0] value;
    logic [4:0]  places;
    logic        eq;
    logic        ovf;
  } dec_result_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         mode;
  logic signed [63:0] a_value;
  logic [4:0]         a_places;
  logic signed [63:0] b_value;
  logic [4:0]         b_places;
  logic [4:0]         target_places;
  logic               out_valid;
  logic               out_stall;
  logic signed [63:0] result_value;
  logic [4:0]         result_places;
  logic               is_equal;
  logic               overflow;

  dec_result_t pending_results[$];
  int          errors;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          holdoff_cycles;

  scaled_decimal_alu u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .a_value(a_value), .a_places(a_places),
    .b_value(b_value), .b_places(b_places), .target_places(target_places),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_value(result_value), .result_places(result_places),
    .is_equal(is_equal), .overflow(overflow)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("scaled_decimal_alu regression: fail");
    $finish;
  end

  // ---------------- decimal arithmetic predictor ----------------

  function automatic logic [63:0] ten_pow(input int unsigned e);
    logic [63:0] p;
    p = 64'd1;
    for (int unsigned i = 0; i < e && i < PLACE_LIMIT; i++) p = p * 64'd10;
    return p;
  endfunction

  function automatic logic [63:0] magnitude(input logic [63:0] v);
    return v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic [63:0] mul_wrap(input logic [63:0] x, input logic [63:0] y,
                                           inout logic ovf);
    logic        neg;
    logic [63:0] mx;
    logic [63:0] my;
    logic [63:0] lim;
    neg = x[63] ^ y[63];
    mx  = magnitude(x);
    my  = magnitude(y);
    lim = neg ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
    if (mx != 0 && my > lim / mx) ovf = 1'b1;
    return x * y;
  endfunction

  function automatic int unsigned clip_places(input logic [4:0] p, inout logic ovf);
    if (p > PLACE_LIMIT) begin
      ovf = 1'b1;
      return PLACE_LIMIT;
    end
    return p;
  endfunction

  function automatic dec_result_t decimal_result(input logic [2:0] m,
      input logic [63:0] a, input logic [4:0] ap, input logic [63:0] b,
      input logic [4:0] bp, input logic [4:0] tp);
    dec_result_t r;
    logic        ovf;
    int unsigned pa;
    int unsigned pb;
    logic [63:0] rv;
    logic [63:0] d;
    logic [63:0] mg;
    logic [63:0] q;
    int unsigned rp;
    ovf = 1'b0;
    rv  = '0;
    rp  = 0;
    r.eq = 1'b0;
    case (m)
      MODE_ADD, MODE_SUB: begin
        pa = clip_places(ap, ovf);
        pb = clip_places(bp, ovf);
        if (pa < pb) begin
          a  = mul_wrap(a, ten_pow(pb - pa), ovf);
          rp = pb;
        end else begin
          b  = mul_wrap(b, ten_pow(pa - pb), ovf);
          rp = pa;
        end
        if (m == MODE_ADD) begin
          rv = a + b;
          if (a[63] == b[63] && rv[63] != a[63]) ovf = 1'b1;
        end else begin
          rv = a - b;
          if (a[63] != b[63] && rv[63] != a[63]) ovf = 1'b1;
        end
      end
      MODE_MUL: begin
        pa = clip_places(ap, ovf);
        pb = clip_places(bp, ovf);
        rv = mul_wrap(a, b, ovf);
        rp = pa + pb;
        if (rp > PLACE_LIMIT) begin
          rp  = PLACE_LIMIT;
          ovf = 1'b1;
        end
      end
      MODE_ROUND: begin
        pa = clip_places(ap, ovf);
        pb = clip_places(tp, ovf);
        if (pa > pb) begin
          d  = ten_pow(pa - pb);
          mg = magnitude(a);
          q  = mg / d;
          // half away from zero on the magnitude
          if ((mg % d) * 64'd2 >= d) q = q + 64'd1;
          rv = a[63] ? (64'd0 - q) : q;
        end else begin
          rv = mul_wrap(a, ten_pow(pb - pa), ovf);
        end
        rp = pb;
      end
      MODE_SHRINK: begin
        pa = clip_places(ap, ovf);
        mg = magnitude(a);
        while (mg != 0 && pa > 0 && mg % 64'd10 == 0) begin
          mg = mg / 64'd10;
          pa--;
        end
        rv = a[63] ? (64'd0 - mg) : mg;
        rp = pa;
      end
      MODE_EQUAL: r.eq = (a == b) && (ap == bp);
      default: ;
    endcase
    r.value  = rv;
    r.places = rp[4:0];
    r.ovf    = ovf;
    return r;
  endfunction

  // ---------------- drive and check ----------------

  task automatic send_item(input logic [2:0] m, input logic [63:0] a, input logic [4:0] ap,
                           input logic [63:0] b, input logic [4:0] bp, input logic [4:0] tp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    mode = m; a_value = a; a_places = ap; b_value = b; b_places = bp; target_places = tp;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(decimal_result(m, a, ap, b, bp, tp));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  initial begin
    out_stall = 1'b1;
    forever begin
      @(negedge clk);
      if (holdoff_cycles > 0) begin
        out_stall = 1'b1;
        holdoff_cycles--;
      end else begin
        out_stall = ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    dec_result_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transaction value=%h places=%0d", $time,
                 result_value, result_places);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        if (result_value !== exp_r.value) begin
          $display("%0t: result_value expected %h actual %h", $time, exp_r.value,
                   result_value);
          errors++;
        end
        if (result_places !== exp_r.places) begin
          $display("%0t: result_places expected %0d actual %0d", $time, exp_r.places,
                   result_places);
          errors++;
        end
        if (is_equal !== exp_r.eq) begin
          $display("%0t: is_equal expected %b actual %b", $time, exp_r.eq, is_equal);
          errors++;
        end
        if (overflow !== exp_r.ovf) begin
          $display("%0t: overflow expected %b actual %b", $time, exp_r.ovf, overflow);
          errors++;
        end
      end
    end
  end

  // ---------------- stimulus ----------------

  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    case ($urandom_range(6))
      0: v = 64'($signed($urandom_range(2000)) - 1000);
      1: v = {$urandom, $urandom};
      2: v = ($urandom_range(1)) ? 64'h8000_0000_0000_0000 : 64'h7fff_ffff_ffff_ffff;
      3: begin
        v = 64'($urandom_range(999)) * ten_pow($urandom_range(16));
        if ($urandom_range(1)) v = 64'd0 - v;
      end
      4: v = '0;
      5: v = 64'($signed($urandom) >>> $urandom_range(31));
      default: v = {{32{1'b0}}, $urandom} ^ {{32{$urandom_range(1) == 1}}, 32'h0};
    endcase
    return v;
  endfunction

  function automatic logic [4:0] pick_places();
    if ($urandom_range(9) == 0) return 5'($urandom_range(31, 19));
    return 5'($urandom_range(PLACE_LIMIT));
  endfunction

  task automatic run_directed();
    logic [63:0] vmax;
    logic [63:0] vmin;
    vmax = 64'h7fff_ffff_ffff_ffff;
    vmin = 64'h8000_0000_0000_0000;
    send_item(MODE_ADD, 64'd15, 5'd1, 64'd3, 5'd3, 5'd0);
    send_item(MODE_ADD, vmax, 5'd0, 64'd1, 5'd0, 5'd0);          // sum overflow
    send_item(MODE_ADD, vmax, 5'd0, 64'd1, 5'd18, 5'd0);         // alignment overflow
    send_item(MODE_ADD, 64'd1, 5'd31, 64'd1, 5'd19, 5'd0);       // places above limit
    send_item(MODE_SUB, vmin, 5'd2, 64'd1, 5'd2, 5'd0);
    send_item(MODE_SUB, 64'd0, 5'd0, vmin, 5'd0, 5'd0);
    send_item(MODE_SUB, 64'd7, 5'd4, 64'd7, 5'd0, 5'd0);
    send_item(MODE_MUL, vmin, 5'd0, 64'hffff_ffff_ffff_ffff, 5'd0, 5'd0);
    send_item(MODE_MUL, 64'd12, 5'd10, 64'd5, 5'd9, 5'd0);       // places sum too big
    send_item(MODE_MUL, vmax, 5'd18, vmax, 5'd0, 5'd0);
    send_item(MODE_ROUND, 64'd15, 5'd1, 64'd0, 5'd0, 5'd0);      // half rounds up
    send_item(MODE_ROUND, 64'hffff_ffff_ffff_fff1, 5'd1, 64'd0, 5'd0, 5'd0); // -15
    send_item(MODE_ROUND, 64'hffff_ffff_ffff_fff2, 5'd1, 64'd0, 5'd0, 5'd0); // -14
    send_item(MODE_ROUND, vmin, 5'd18, 64'd0, 5'd0, 5'd0);
    send_item(MODE_ROUND, vmax, 5'd0, 64'd0, 5'd0, 5'd18);       // scale-up overflow
    send_item(MODE_ROUND, 64'd9, 5'd3, 64'd0, 5'd0, 5'd31);
    send_item(MODE_SHRINK, 64'd1000, 5'd3, 64'd0, 5'd0, 5'd0);
    send_item(MODE_SHRINK, 64'd1000, 5'd1, 64'd0, 5'd0, 5'd0);  // stops at zero places
    send_item(MODE_SHRINK, 64'd0, 5'd18, 64'd0, 5'd0, 5'd0);
    send_item(MODE_SHRINK, 64'd0 - ten_pow(18), 5'd25, 64'd0, 5'd0, 5'd0);
    send_item(MODE_SHRINK, vmin, 5'd18, 64'd0, 5'd0, 5'd0);
    send_item(MODE_EQUAL, vmin, 5'd31, vmin, 5'd31, 5'd0);
    send_item(MODE_EQUAL, 64'd10, 5'd1, 64'd10, 5'd2, 5'd0);
    send_item(MODE_SPARE6, vmax, 5'd31, vmin, 5'd31, 5'd31);
    send_item(MODE_SPARE7, 64'd5, 5'd1, 64'd5, 5'd1, 5'd1);
  endtask

  task automatic run_random(input int count);
    logic [2:0] m;
    for (int i = 0; i < count; i++) begin
      m = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
      send_item(m, pick_value(), pick_places(), pick_value(), pick_places(), pick_places());
    end
  endtask

  // receiver holds off long enough for the queue to fill and stall the input
  task automatic run_backpressure();
    send_idle_pct  = 0;
    holdoff_cycles = 600;
    run_random(12);
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    while (pending_results.size() != 0 && guard < 2000000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    errors = 0;
    holdoff_cycles = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    rst = 1'b1;
    in_valid = 1'b0;
    mode = MODE_ADD;
    a_value = '0;
    a_places = '0;
    b_value = '0;
    b_places = '0;
    target_places = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_idle_pct = 15;
    recv_idle_pct = 61;
    run_directed();
    run_random(130);
    send_idle_pct = 61;
    recv_idle_pct = 15;
    run_random(130);
    recv_idle_pct = 0;
    run_backpressure();
    send_idle_pct = 0;
    run_random(130);
    wait_drained();

    if (errors == 0 && pending_results.size() == 0) begin
      $display("scaled_decimal_alu regression: pass");
    end else begin
      $display("scaled_decimal_alu regression: fail");
    end
    $finish;
  end

endmodule
